/* sv/rc2bd_pkg.sv */
// Shared types, constants and helper functions for the RC2 block decrypter.
`default_nettype none

package rc2bd_pkg;

    localparam int KEY_DEPTH = 64;
    localparam int KEY_AW    = 6;
    localparam int WORD_W    = 16;
    localparam int BLOCK_W   = 64;

    localparam logic [3:0] LAST_ROUND    = 4'd15;
    localparam logic [3:0] MASH_ROUND_HI = 4'd10;
    localparam logic [3:0] MASH_ROUND_LO = 4'd4;
    localparam logic [1:0] WORD_HI       = 2'd3;

    localparam logic [KEY_AW-1:0] FIRST_KEY_ADDR = {LAST_ROUND, WORD_HI};

    localparam logic ACT_KEY     = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } t_state;

    // Control from the sequencer to the word datapath and the key table write port
    typedef struct packed {
        logic       key_we;
        logic       load;
        logic       step;
        logic       mash;
        logic [1:0] sel;
    } t_step_ctrl;

    // Right-rotate amount of each word in the inverse mix
    function automatic logic [3:0] rot_amt(input logic [1:0] sel);
        logic [3:0] amt;
        case (sel)
            2'd3:    amt = 4'd5;
            2'd2:    amt = 4'd3;
            2'd1:    amt = 4'd2;
            default: amt = 4'd1;
        endcase
        return amt;
    endfunction

    function automatic logic [WORD_W-1:0] rotr16(input logic [WORD_W-1:0] w,
                                                 input logic [3:0] amt);
        logic [2*WORD_W-1:0] dbl;
        dbl = {w, w} >> amt;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* sv/rc2bd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rc2bd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/rc2bd_round.sv */
// Word registers and the shared inverse mix / mash unit, one word per cycle.
`default_nettype none

module rc2bd_round
    import rc2bd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_step_ctrl         i_ctl,
    input  wire logic [BLOCK_W-1:0] i_cipher_block,
    input  wire logic [WORD_W-1:0]  i_key,
    output logic      [KEY_AW-1:0]  o_mash_addr,
    output logic      [BLOCK_W-1:0] o_block
);

    // p0 is the word being updated (w_j), p1 = w_j+1, p2 = w_j+2, p3 = w_j-1.
    // After each update the ring turns so the next lower word lands in p0.
    logic [WORD_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic [WORD_W-1:0] n_p0, n_p1, n_p2, n_p3;
    logic [WORD_W-1:0] mix_f;
    logic [WORD_W-1:0] new_word;

    always_comb begin
        mix_f = (r_p1 & ~r_p3) + (r_p2 & r_p3);
        if (i_ctl.mash) begin
            new_word = r_p0 - i_key;
        end else begin
            new_word = rotr16(r_p0, rot_amt(i_ctl.sel)) - (mix_f + i_key);
        end

        n_p0 = r_p0;
        n_p1 = r_p1;
        n_p2 = r_p2;
        n_p3 = r_p3;
        if (i_ctl.load) begin
            n_p0 = i_cipher_block[63:48];
            n_p1 = i_cipher_block[15:0];
            n_p2 = i_cipher_block[31:16];
            n_p3 = i_cipher_block[47:32];
        end else if (i_ctl.step) begin
            n_p0 = r_p3;
            n_p1 = new_word;
            n_p2 = r_p1;
            n_p3 = r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        r_p2 <= n_p2;
        r_p3 <= n_p3;
    end

    // Next mash step reads the key at the word that moves into p3
    assign o_mash_addr = r_p2[KEY_AW-1:0];
    assign o_block     = {r_p0, r_p3, r_p2, r_p1};

endmodule

`default_nettype wire

/* sv/rc2bd_seq.sv */
// Round / word sequencer and key table read address generation.
`default_nettype none

module rc2bd_seq
    import rc2bd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_action,
    input  wire logic              i_out_free,
    input  wire logic [KEY_AW-1:0] i_mash_addr,
    output logic                   o_in_stall,
    output t_step_ctrl             o_ctl,
    output logic      [KEY_AW-1:0] o_raddr,
    output logic                   o_done
);

    t_state     r_state, n_state;
    logic [3:0] r_round, n_round;
    logic       r_mash, n_mash;
    logic [1:0] r_sel, n_sel;

    logic [3:0] nx_round;
    logic       nx_mash;
    logic [1:0] nx_sel;
    logic       last_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= LAST_ROUND;
            r_mash  <= 1'b0;
            r_sel   <= WORD_HI;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_mash  <= n_mash;
            r_sel   <= n_sel;
        end
    end

    // Step that follows the current one
    always_comb begin
        nx_round = r_round;
        nx_mash  = r_mash;
        nx_sel   = r_sel - 2'd1;
        if (r_sel == '0) begin
            nx_sel = WORD_HI;
            if (r_mash) begin
                nx_mash = 1'b0;
            end else begin
                nx_round = r_round - 4'd1;
                nx_mash  = nx_round inside {MASH_ROUND_HI, MASH_ROUND_LO};
            end
        end
        last_step = (r_round == '0) && !r_mash && (r_sel == '0);
    end

    always_comb begin
        n_state    = r_state;
        n_round    = r_round;
        n_mash     = r_mash;
        n_sel      = r_sel;
        o_in_stall = 1'b1;
        o_done     = 1'b0;
        o_raddr    = FIRST_KEY_ADDR;
        o_ctl      = '0;
        o_ctl.mash = r_mash;
        o_ctl.sel  = r_sel;

        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == ACT_DECRYPT) begin
                        o_ctl.load = 1'b1;
                        n_round    = LAST_ROUND;
                        n_mash     = 1'b0;
                        n_sel      = WORD_HI;
                        n_state    = ST_RUN;
                    end else begin
                        o_ctl.key_we = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                o_ctl.step = 1'b1;
                // Prefetch the key for the next step; mash keys come from the words
                o_raddr    = nx_mash ? i_mash_addr : {nx_round, nx_sel};
                if (last_step) begin
                    n_state = ST_FINISH;
                end else begin
                    n_round = nx_round;
                    n_mash  = nx_mash;
                    n_sel   = nx_sel;
                end
            end
            ST_FINISH: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/rc2_block_decrypt.sv */
// RC2 ECB block decrypter: key table, sequencer, shared round unit, output register.
// A decrypt request, once accepted, runs through 72 word steps (16 rounds of four
// words plus two mashing passes of four), one per cycle through the single round unit
// and key table read port, then a finish state that waits for a free output register.
// No new block or key load is taken until the sequencer is back in idle.
// Reset (synchronous, active low) clears the sequencer and the output valid; the
// key table is not cleared and must be loaded before decrypting.
`default_nettype none

module rc2_block_decrypt
    import rc2bd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_action,
    input  wire logic [KEY_AW-1:0]  i_key_index,
    input  wire logic [WORD_W-1:0]  i_key_word,
    input  wire logic [BLOCK_W-1:0] i_cipher_block,
    input  wire logic               i_final_block,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic      [BLOCK_W-1:0] o_plain_block,
    output logic                    o_final_out
);

    t_step_ctrl         ctl;
    logic [KEY_AW-1:0]  raddr;
    logic [KEY_AW-1:0]  mash_addr;
    logic [WORD_W-1:0]  key;
    logic [BLOCK_W-1:0] block;
    logic               done;
    logic               out_free;

    logic               r_final;
    logic               r_out_valid;
    logic [BLOCK_W-1:0] r_plain_block;
    logic               r_final_out;

    assign out_free = !r_out_valid || !i_out_stall;

    rc2bd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_free  (out_free),
        .i_mash_addr (mash_addr),
        .o_in_stall  (o_in_stall),
        .o_ctl       (ctl),
        .o_raddr     (raddr),
        .o_done      (done)
    );

    rc2bd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ctl.key_we),
        .i_waddr (i_key_index),
        .i_wdata (i_key_word),
        .i_raddr (raddr),
        .o_rdata (key)
    );

    rc2bd_round u_round (
        .i_clk          (i_clk),
        .i_ctl          (ctl),
        .i_cipher_block (i_cipher_block),
        .i_key          (key),
        .o_mash_addr    (mash_addr),
        .o_block        (block)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_final <= i_final_block;
        end
        if (done) begin
            r_plain_block <= block;
            r_final_out   <= r_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_plain_block = r_plain_block;
    assign o_final_out   = r_final_out;

endmodule

`default_nettype wire

/* tb/sv/rc2_plaintext_checker.sv */
// Checker for the RC2 block decrypter: tracks the key table, predicts plaintext, compares.
`default_nettype none

module rc2_plaintext_checker
    import rc2bd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic               i_action,
    input  wire logic [KEY_AW-1:0]  i_key_index,
    input  wire logic [WORD_W-1:0]  i_key_word,
    input  wire logic [BLOCK_W-1:0] i_cipher_block,
    input  wire logic               i_final_block,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic [BLOCK_W-1:0] i_plain_block,
    input  wire logic               i_final_out,
    output int                      o_fail_count,
    output int                      o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BLOCK_W-1:0] plain;
        logic               last;
    } t_plain_due;

    logic [WORD_W-1:0] key_shadow [KEY_DEPTH];
    t_plain_due        plain_due [$];
    int                fail_count = 0;
    int                due_count  = 0;

    assign o_fail_count = fail_count;
    assign o_due_count  = due_count;

    function automatic logic [WORD_W-1:0] ror16(input logic [WORD_W-1:0] w, input int n);
        return (w >> n) | (w << (WORD_W - n));
    endfunction

    // Inverse mixing rounds 15..0, inverse mash ahead of rounds 10 and 4
    function automatic logic [BLOCK_W-1:0] predict_plain(input logic [BLOCK_W-1:0] blk);
        logic [WORD_W-1:0] w0, w1, w2, w3;
        int base;
        {w3, w2, w1, w0} = blk;
        for (int r = int'(LAST_ROUND); r >= 0; r--) begin
            base = r * 4;
            if (r == int'(MASH_ROUND_HI) || r == int'(MASH_ROUND_LO)) begin
                w3 = w3 - key_shadow[w2[KEY_AW-1:0]];
                w2 = w2 - key_shadow[w1[KEY_AW-1:0]];
                w1 = w1 - key_shadow[w0[KEY_AW-1:0]];
                w0 = w0 - key_shadow[w3[KEY_AW-1:0]];
            end
            w3 = ror16(w3, 5) - ((w0 & ~w2) + (w1 & w2) + key_shadow[KEY_AW'(base + 3)]);
            w2 = ror16(w2, 3) - ((w3 & ~w1) + (w0 & w1) + key_shadow[KEY_AW'(base + 2)]);
            w1 = ror16(w1, 2) - ((w2 & ~w0) + (w3 & w0) + key_shadow[KEY_AW'(base + 1)]);
            w0 = ror16(w0, 1) - ((w1 & ~w3) + (w2 & w3) + key_shadow[KEY_AW'(base)]);
        end
        return {w3, w2, w1, w0};
    endfunction

    always @(posedge i_clk) begin : watch
        t_plain_due exp_item;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (plain_due.size() == 0) begin
                    $error("unexpected result: plain_block %h final_out %b",
                           i_plain_block, i_final_out);
                    fail_count++;
                end else begin
                    exp_item = plain_due.pop_front();
                    if (i_plain_block !== exp_item.plain) begin
                        $error("plain_block: expected %h, got %h",
                               exp_item.plain, i_plain_block);
                        fail_count++;
                    end
                    if (i_final_out !== exp_item.last) begin
                        $error("final_out: expected %b, got %b",
                               exp_item.last, i_final_out);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action == ACT_KEY) begin
                    key_shadow[i_key_index] = i_key_word;
                end else begin
                    exp_item.plain = predict_plain(i_cipher_block);
                    exp_item.last  = i_final_block;
                    plain_due.push_back(exp_item);
                end
            end
            due_count = plain_due.size();
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Top of the RC2 block decrypter testbench: clock, reset, request stimulus, verdict.
`default_nettype none

module tb_top;
    import rc2bd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS          = 1550;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 150;

    typedef enum int {
        FILL_ZERO,
        FILL_ONES,
        FILL_RANDOM
    } t_fill;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               in_valid     = 1'b0;
    logic               act          = ACT_KEY;
    logic [KEY_AW-1:0]  key_index    = '0;
    logic [WORD_W-1:0]  key_word     = '0;
    logic [BLOCK_W-1:0] cipher_block = '0;
    logic               final_block  = 1'b0;
    logic               out_stall    = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [BLOCK_W-1:0] plain_block;
    logic               final_out;
    int                 fail_count;
    int                 due_count;
    int                 sent     = 0;
    int                 idle_cnt = 0;
    logic               no_gap   = 1'b0;

    rc2_block_decrypt DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_action       (act),
        .i_key_index    (key_index),
        .i_key_word     (key_word),
        .i_cipher_block (cipher_block),
        .i_final_block  (final_block),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_plain_block  (plain_block),
        .o_final_out    (final_out)
    );

    rc2_plaintext_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_action       (act),
        .i_key_index    (key_index),
        .i_key_word     (key_word),
        .i_cipher_block (cipher_block),
        .i_final_block  (final_block),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_plain_block  (plain_block),
        .i_final_out    (final_out),
        .o_fail_count   (fail_count),
        .o_due_count    (due_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cycles with no request moving on either side
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cnt <= 0;
        end else if (idle_cnt + 1 >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    // Result side: random stall before each result, with stall-free stretches
    initial begin : result_side
        int hold;
        int taken;
        logic no_hold;
        taken   = 0;
        no_hold = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 40 == 0) no_hold = ($urandom_range(0, 3) == 0);
            hold = no_hold ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            taken++;
        end
    end

    // Returns at the edge where the request is taken
    task automatic send_req(input logic a, input logic [KEY_AW-1:0] idx,
                            input logic [WORD_W-1:0] word, input logic [BLOCK_W-1:0] blk,
                            input logic last);
        int gap;
        if (sent % 48 == 0) no_gap = ($urandom_range(0, 3) == 0);
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        act          <= a;
        key_index    <= idx;
        key_word     <= word;
        cipher_block <= blk;
        final_block  <= last;
        do @(posedge i_clk); while (in_stall);
        sent++;
    endtask

    function automatic logic [BLOCK_W-1:0] rand_block();
        return {$urandom, $urandom};
    endfunction

    // Unused fields carry random values; the block must ignore them
    task automatic load_key(input logic [KEY_AW-1:0] idx, input logic [WORD_W-1:0] word);
        send_req(ACT_KEY, idx, word, rand_block(), 1'($urandom_range(0, 1)));
    endtask

    task automatic decrypt(input logic [BLOCK_W-1:0] blk, input logic last);
        send_req(ACT_DECRYPT, KEY_AW'($urandom_range(0, KEY_DEPTH - 1)),
                 WORD_W'($urandom_range(0, 16'hFFFF)), blk, last);
    endtask

    task automatic fill_keys(input t_fill pattern);
        logic [WORD_W-1:0] word;
        for (int k = 0; k < KEY_DEPTH; k++) begin
            case (pattern)
                FILL_ZERO: word = '0;
                FILL_ONES: word = '1;
                default:   word = WORD_W'($urandom_range(0, 16'hFFFF));
            endcase
            load_key(KEY_AW'(k), word);
        end
    endtask

    initial begin : stimulus
        int pick;
        logic [BLOCK_W-1:0] blk;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Whole table must be written before the first decrypt
        fill_keys(FILL_RANDOM);
        load_key('0, 16'h0000);
        load_key(KEY_AW'(KEY_DEPTH - 1), 16'hFFFF);

        decrypt('0, 1'b0);
        decrypt('1, 1'b1);
        decrypt(64'h0123_4567_89AB_CDEF, 1'b0);
        decrypt(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        decrypt(64'h5555_5555_5555_5555, 1'b1);
        decrypt(64'h8000_0000_0000_0001, 1'b0);
        decrypt(64'h0000_FFFF_0000_FFFF, 1'b1);
        load_key(6'd5, 16'h8001);
        decrypt(64'h0000_FFFF_0000_FFFF, 1'b0);

        while (sent < ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                // full rewrite, sometimes to an extreme table
                case ($urandom_range(0, 2))
                    0:       fill_keys(FILL_ZERO);
                    1:       fill_keys(FILL_ONES);
                    default: fill_keys(FILL_RANDOM);
                endcase
            end else if (pick < 15) begin
                load_key(KEY_AW'($urandom_range(0, KEY_DEPTH - 1)),
                         WORD_W'($urandom_range(0, 16'hFFFF)));
            end else begin
                case ($urandom_range(0, 19))
                    0:       blk = '0;
                    1:       blk = '1;
                    2:       blk = 64'd1 << $urandom_range(0, BLOCK_W - 1);
                    default: blk = rand_block();
                endcase
                decrypt(blk, $urandom_range(0, 7) == 0);
            end
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
